@@ rtl/vpd_pkg.sv @@
// Shared constants and types for the VP9 payload descriptor parser.
package vpd_pkg;

    localparam int BYTE_W   = 8;
    localparam int FLAGS_W  = 7;
    localparam int PID_W    = 15;
    localparam int FORM_W   = 2;
    localparam int IDX_W    = 3;
    localparam int PHASE_W  = 3;
    localparam int OUT_DATA_W = 48;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PID1  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PID2  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LAYER = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TL0   = 3'd4;

    localparam logic [FORM_W-1:0] FORM_NONE  = 2'd0;
    localparam logic [FORM_W-1:0] FORM_SHORT = 2'd1;
    localparam logic [FORM_W-1:0] FORM_LONG  = 2'd2;

    localparam logic ST_DONE      = 1'b0;
    localparam logic ST_TRUNCATED = 1'b1;

    // flag bit positions within header_flags
    localparam int FLAG_I = 6;
    localparam int FLAG_P = 5;
    localparam int FLAG_L = 4;
    localparam int FLAG_F = 3;
    localparam int FLAG_B = 2;

    typedef struct packed {
        logic               status;
        logic [FLAGS_W-1:0] header_flags;
        logic [PID_W-1:0]   picture_id;
        logic [FORM_W-1:0]  picture_id_form;
        logic [IDX_W-1:0]   spatial_index;
        logic [IDX_W-1:0]   temporal_index;
        logic               switching_up;
        logic               inter_layer_dep;
        logic [BYTE_W-1:0]  tl0_index;
        logic               has_tl0_index;
        logic               key_frame;
    } desc_t;

    function automatic logic [OUT_DATA_W-1:0] pack_desc(input desc_t d);
        pack_desc = {6'b0, d.key_frame, d.has_tl0_index, d.tl0_index, d.inter_layer_dep,
                     d.switching_up, d.temporal_index, d.spatial_index,
                     d.picture_id_form, d.picture_id, d.header_flags};
    endfunction

endpackage

@@ rtl/vp9_payload_descriptor_parser_core.sv @@
// VP9 RTP payload descriptor parser: byte-serial decode into at most one descriptor per packet.
// An accepted byte is captured in the input register and decoded from it; its result,
// if any, is written to the result register once that register is free or being taken.
// Throughput: one payload byte per cycle; the input stalls only while the result
// register holds an untaken descriptor.
// Reset: rst_n clears both valid bits and the parse state (phase idle, fields zero).
module vp9_payload_descriptor_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [vpd_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] payload_byte
    input  logic                         s_axis_tuser,  // [0] first_of_packet
    input  logic                         s_axis_tlast,  // last_of_packet
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [6:0] header_flags, [21:7] picture_id, [23:22] picture_id_form,
    // [26:24] spatial_index, [29:27] temporal_index, [30] switching_up,
    // [31] inter_layer_dep, [39:32] tl0_index, [40] has_tl0_index, [41] key_frame
    output logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser   // [0] status
);
    import vpd_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_first_reg;
    logic               in_last_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [FORM_W-1:0]  form_reg, form_next;
    logic [BYTE_W-1:0]  layer_reg, layer_next;

    logic               out_valid_reg, out_valid_next;
    desc_t              out_reg;
    desc_t              desc;
    logic               emit;
    logic               advance;
    logic               in_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic       done;
        logic       has_layer;
        logic       has_tl0;
        logic       cont;
        logic [IDX_W-1:0] sl;

        phase_next = phase_reg;
        flags_next = flags_reg;
        pid_next   = pid_reg;
        form_next  = form_reg;
        layer_next = layer_reg;
        done       = 1'b0;
        has_layer  = 1'b0;
        has_tl0    = 1'b0;
        cont       = 1'b1;

        if (in_first_reg)
        begin
            flags_next = in_byte_reg[7:1];
            pid_next   = '0;
            form_next  = FORM_NONE;
            layer_next = '0;
            if (in_byte_reg[FLAG_I+1])
                phase_next = PH_PID1;
            else if (in_byte_reg[FLAG_L+1])
                phase_next = PH_LAYER;
            else
                done = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_PID1:
                begin
                    if (in_byte_reg[7])
                    begin
                        pid_next   = {in_byte_reg[6:0], 8'b0};
                        form_next  = FORM_LONG;
                        phase_next = PH_PID2;
                    end
                    else
                    begin
                        pid_next  = {8'b0, in_byte_reg[6:0]};
                        form_next = FORM_SHORT;
                        if (!flags_reg[FLAG_L])
                            done = 1'b1;
                        else
                            phase_next = PH_LAYER;
                    end
                end
                PH_PID2:
                begin
                    pid_next = pid_reg | {7'b0, in_byte_reg};
                    if (!flags_reg[FLAG_L])
                        done = 1'b1;
                    else
                        phase_next = PH_LAYER;
                end
                PH_LAYER:
                begin
                    layer_next = in_byte_reg;
                    phase_next = PH_TL0;
                end
                PH_TL0:
                begin
                    done      = 1'b1;
                    has_layer = 1'b1;
                    has_tl0   = !flags_reg[FLAG_F];
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cont       = 1'b0;
                end
            endcase
        end

        sl = has_layer ? layer_next[3:1] : '0;
        desc = '0;
        desc.header_flags = flags_next;
        emit = 1'b0;
        if (done)
        begin
            emit                 = 1'b1;
            phase_next           = PH_IDLE;
            desc.status          = ST_DONE;
            desc.picture_id      = pid_next;
            desc.picture_id_form = form_next;
            if (has_layer)
            begin
                desc.spatial_index   = sl;
                desc.temporal_index  = layer_next[7:5];
                desc.switching_up    = layer_next[4];
                desc.inter_layer_dep = layer_next[0];
            end
            if (has_tl0)
            begin
                desc.tl0_index     = in_byte_reg;
                desc.has_tl0_index = 1'b1;
            end
            desc.key_frame = !flags_next[FLAG_P] && flags_next[FLAG_B] && (sl == '0);
        end
        else if (cont && in_last_reg)
        begin
            emit        = 1'b1;
            phase_next  = PH_IDLE;
            desc.status = ST_TRUNCATED;
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance)
            out_valid_next = in_valid_reg && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            flags_reg     <= '0;
            pid_reg       <= '0;
            form_reg      <= FORM_NONE;
            layer_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (in_valid_reg && advance)
            begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                pid_reg   <= pid_next;
                form_reg  <= form_next;
                layer_reg <= layer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
        if (in_valid_reg && advance && emit)
            out_reg <= desc;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pack_desc(out_reg);
    assign m_axis_tuser  = out_reg.status;

    a_trunc_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.status == ST_TRUNCATED) |->
        (out_reg.picture_id == '0 && out_reg.picture_id_form == FORM_NONE &&
         !out_reg.has_tl0_index && !out_reg.key_frame))
        else $error("truncated item carries descriptor fields");

    a_tl0_needs_layer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.has_tl0_index) |->
        (out_reg.header_flags[FLAG_L] && !out_reg.header_flags[FLAG_F]))
        else $error("TL0 index reported without L set and F clear");

    a_key_frame_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.key_frame) |->
        (!out_reg.header_flags[FLAG_P] && out_reg.header_flags[FLAG_B] &&
         out_reg.spatial_index == '0))
        else $error("key frame flag inconsistent with header flags");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PID2) |-> (form_reg == FORM_LONG && flags_reg[FLAG_I]))
        else $error("second picture id byte expected without long form");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the VP9 payload descriptor parser core.
`timescale 1ns / 100ps

module tb;
    import vpd_pkg::*;

    localparam int CALM_ITEMS = 60;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                first;
        bit                last;
    } payload_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    payload_item_t byte_queue[$];
    desc_t         desc_queue[$];
    int            fail_count = 0;
    int            in_gap = 0;
    int            out_stall = 0;

    // predictor state
    logic [PHASE_W-1:0] phase_q = PH_IDLE;
    logic [FLAGS_W-1:0] flags_q = '0;
    logic [PID_W-1:0]   pid_q = '0;
    logic [FORM_W-1:0]  form_q = FORM_NONE;
    logic [BYTE_W-1:0]  layer_q = '0;

    vp9_payload_descriptor_parser_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic desc_t finish_desc(input bit has_layer, input bit has_tl0,
                                          input logic [BYTE_W-1:0] tl0);
        desc_t d;
        d = '0;
        d.status          = ST_DONE;
        d.header_flags    = flags_q;
        d.picture_id      = pid_q;
        d.picture_id_form = form_q;
        if (has_layer)
        begin
            d.spatial_index   = layer_q[3:1];
            d.temporal_index  = layer_q[7:5];
            d.switching_up    = layer_q[4];
            d.inter_layer_dep = layer_q[0];
        end
        if (has_tl0)
        begin
            d.tl0_index     = tl0;
            d.has_tl0_index = 1'b1;
        end
        d.key_frame = !flags_q[FLAG_P] && flags_q[FLAG_B] && (d.spatial_index == '0);
        phase_q = PH_IDLE;
        return d;
    endfunction

    // returns 1 when the byte completes or truncates a descriptor
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input bit first,
                                       input bit last, output desc_t d);
        d = '0;
        if (first)
        begin
            flags_q = b[7:1];
            pid_q   = '0;
            form_q  = FORM_NONE;
            layer_q = '0;
            if (flags_q[FLAG_I])
                phase_q = PH_PID1;
            else if (flags_q[FLAG_L])
                phase_q = PH_LAYER;
            else
            begin
                d = finish_desc(1'b0, 1'b0, '0);
                return 1'b1;
            end
        end
        else
        begin
            case (phase_q)
                PH_PID1:
                begin
                    if (b[7])
                    begin
                        pid_q   = {b[6:0], 8'h00};
                        form_q  = FORM_LONG;
                        phase_q = PH_PID2;
                    end
                    else
                    begin
                        pid_q  = {8'h00, b[6:0]};
                        form_q = FORM_SHORT;
                        if (!flags_q[FLAG_L])
                        begin
                            d = finish_desc(1'b0, 1'b0, '0);
                            return 1'b1;
                        end
                        phase_q = PH_LAYER;
                    end
                end
                PH_PID2:
                begin
                    pid_q = pid_q | {7'h00, b};
                    if (!flags_q[FLAG_L])
                    begin
                        d = finish_desc(1'b0, 1'b0, '0);
                        return 1'b1;
                    end
                    phase_q = PH_LAYER;
                end
                PH_LAYER:
                begin
                    layer_q = b;
                    phase_q = PH_TL0;
                end
                PH_TL0:
                begin
                    if (flags_q[FLAG_F])
                        d = finish_desc(1'b1, 1'b0, '0);
                    else
                        d = finish_desc(1'b1, 1'b1, b);
                    return 1'b1;
                end
                default:
                begin
                    phase_q = PH_IDLE;
                    return 1'b0;
                end
            endcase
        end
        if (last)
        begin
            d = '0;
            d.status       = ST_TRUNCATED;
            d.header_flags = flags_q;
            phase_q        = PH_IDLE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int desc_len(input logic [FLAGS_W-1:0] flg, input bit m);
        int n;
        n = 1;
        if (flg[FLAG_I])
            n += m ? 2 : 1;
        if (flg[FLAG_L])
            n += 2;
        return n;
    endfunction

    // n bytes of a packet; bytes past the descriptor are random filler
    task automatic send_packet(input logic [FLAGS_W-1:0] flg, input bit m,
                               input logic [PID_W-1:0] pid, input logic [BYTE_W-1:0] layer,
                               input logic [BYTE_W-1:0] tl0, input int n, input bit mark_last);
        logic [BYTE_W-1:0] bytes[$];
        bit                z;
        int                k;
        z = 1'($urandom_range(0, 1));
        bytes.push_back({flg, z});
        if (flg[FLAG_I])
        begin
            if (m)
            begin
                bytes.push_back({1'b1, pid[14:8]});
                bytes.push_back(pid[7:0]);
            end
            else
                bytes.push_back({1'b0, pid[6:0]});
        end
        if (flg[FLAG_L])
        begin
            bytes.push_back(layer);
            bytes.push_back(tl0);
        end
        while (bytes.size() < n)
            bytes.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < n; k++)
            byte_queue.push_back(payload_item_t'{bytes[k], k == 0, mark_last && (k == n - 1)});
    endtask

    task automatic report(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // stimulus feeder
    always @(posedge clk)
    begin
        payload_item_t it;
        desc_t         d;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, d))
                    desc_queue.push_back(d);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (byte_queue.size() > 0)
                begin
                    it = byte_queue.pop_front();
                    s_axis_tdata  <= it.data;
                    s_axis_tuser  <= it.first;
                    s_axis_tlast  <= it.last;
                    s_axis_tvalid <= 1'b1;
                    if (byte_queue.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
                        in_gap <= $urandom_range(1, 6);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        desc_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (desc_queue.size() == 0)
                    report("descriptor with none pending");
                else
                begin
                    want = desc_queue.pop_front();
                    check_field("status", 16'(m_axis_tuser), 16'(want.status));
                    check_field("header_flags", 16'(m_axis_tdata[6:0]),
                                16'(want.header_flags));
                    check_field("picture_id", 16'(m_axis_tdata[21:7]),
                                16'(want.picture_id));
                    check_field("picture_id_form", 16'(m_axis_tdata[23:22]),
                                16'(want.picture_id_form));
                    check_field("spatial_index", 16'(m_axis_tdata[26:24]),
                                16'(want.spatial_index));
                    check_field("temporal_index", 16'(m_axis_tdata[29:27]),
                                16'(want.temporal_index));
                    check_field("switching_up", 16'(m_axis_tdata[30]),
                                16'(want.switching_up));
                    check_field("inter_layer_dep", 16'(m_axis_tdata[31]),
                                16'(want.inter_layer_dep));
                    check_field("tl0_index", 16'(m_axis_tdata[39:32]),
                                16'(want.tl0_index));
                    check_field("has_tl0_index", 16'(m_axis_tdata[40]),
                                16'(want.has_tl0_index));
                    check_field("key_frame", 16'(m_axis_tdata[41]),
                                16'(want.key_frame));
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (byte_queue.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
            begin
                out_stall <= $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [FLAGS_W-1:0] flg;
        logic [PID_W-1:0]   pid;
        logic [BYTE_W-1:0]  layer;
        logic [BYTE_W-1:0]  tl0;
        bit                 m;
        int                 full;
        int                 sel;

        // bytes while idle are dropped
        byte_queue.push_back(payload_item_t'{8'hFF, 1'b0, 1'b1});
        byte_queue.push_back(payload_item_t'{8'h00, 1'b0, 1'b0});
        // lone header byte, key frame
        send_packet(7'h04, 1'b0, '0, '0, '0, 1, 1'b1);
        // all flags, long id, flexible mode so no TL0 index
        send_packet(7'h7F, 1'b1, 15'h7FFF, 8'hFF, 8'hFF, 5, 1'b1);
        // short id with layer byte and TL0 index
        send_packet(7'h50, 1'b0, 15'h007F, 8'h00, 8'hAB, 4, 1'b1);
        // long id zero, spatial index one, trailing bytes ignored
        send_packet(7'h54, 1'b1, 15'h0000, 8'h02, 8'h33, 7, 1'b1);
        // short id only
        send_packet(7'h40, 1'b0, 15'h0055, '0, '0, 2, 1'b1);
        // truncated inside a long id
        send_packet(7'h50, 1'b1, 15'h1234, '0, '0, 2, 1'b1);
        // abandoned by the next first mark
        send_packet(7'h10, 1'b0, '0, '0, '0, 1, 1'b0);
        // truncated before the TL0 byte
        send_packet(7'h14, 1'b0, '0, 8'hE1, 8'h5A, 2, 1'b1);

        while (byte_queue.size() < 470)
        begin
            flg   = 7'($urandom_range(0, 127));
            m     = 1'($urandom_range(0, 1));
            pid   = 15'($urandom_range(0, 32767));
            layer = 8'($urandom_range(0, 255));
            tl0   = 8'($urandom_range(0, 255));
            full  = desc_len(flg, m);
            sel   = $urandom_range(0, 99);
            if (sel < 70)
                send_packet(flg, m, pid, layer, tl0, full + $urandom_range(0, 3), 1'b1);
            else if (sel < 85)
                send_packet(flg, m, pid, layer, tl0, $urandom_range(1, full), 1'b1);
            else if (sel < 93)
                send_packet(flg, m, pid, layer, tl0, $urandom_range(1, full), 1'b0);
            else
                byte_queue.push_back(payload_item_t'{8'($urandom_range(0, 255)), 1'b0,
                                                     $urandom_range(0, 1) == 1});
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (desc_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vpd_pkg.sv
rtl/vp9_payload_descriptor_parser_core.sv
tb/tb.sv
